@@ src/bjct_pkg.sv @@
// Package for the ball-joint constraint terms block: widths, microcode
// field types, the control program ROM and saturation helpers.
// Standalone; used by ball_joint_constraint_terms.
package bjct_pkg;

  // Field widths
  localparam int unsigned PW      = 32;           // Q16.16 positions and anchors
  localparam int unsigned QW      = 16;           // Q1.14 quaternion parts
  localparam int unsigned CFG_IW  = 3;            // register index width
  localparam int unsigned TW      = 37;           // t = round(2(u x v))
  localparam int unsigned PRODW   = QW + TW;      // shared multiplier output
  localparam int unsigned ACCW    = PRODW + 3;    // accumulator with headroom
  localparam int unsigned SUMW    = PW + 12;      // anchor plus rotation term
  localparam int unsigned PTW     = PW + 1;       // stored point pos + ri
  localparam int unsigned T_SHIFT = 13;
  localparam int unsigned O_SHIFT = 14;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_ANCHOR_A_X = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ANCHOR_A_Y = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ANCHOR_A_Z = 3'd2;
  localparam logic [CFG_IW-1:0] REG_ANCHOR_B_X = 3'd3;
  localparam logic [CFG_IW-1:0] REG_ANCHOR_B_Y = 3'd4;
  localparam logic [CFG_IW-1:0] REG_ANCHOR_B_Z = 3'd5;

  // Program layout
  localparam int unsigned PC_W     = 5;
  localparam logic [PC_W-1:0] PC_EMIT = 5'd20;

  typedef enum logic [1:0] {Q_W, Q_X, Q_Y, Q_Z} q_sel_e;
  typedef enum logic [2:0] {B_V0, B_V1, B_V2, B_T0, B_T1, B_T2} b_sel_e;
  typedef enum logic [1:0] {ACC_NOP, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_e;
  typedef enum logic [3:0] {
    WB_NONE, WB_T0, WB_T1, WB_T2, WB_O0, WB_O1, WB_O2, WB_STORE, WB_EMIT
  } wb_e;
  typedef enum logic [1:0] {SEQ_NEXT, SEQ_BRANCH_B, SEQ_HALT} seq_e;

  typedef struct packed {
    q_sel_e          q_sel;
    b_sel_e          b_sel;
    acc_op_e         acc_op;
    wb_e             wb;
    seq_e            seq;
    logic [PC_W-1:0] target;
  } uword_t;

  function automatic uword_t mk(q_sel_e q, b_sel_e b, acc_op_e a, wb_e w, seq_e s,
                                logic [PC_W-1:0] tgt);
    uword_t u;
    u.q_sel  = q;
    u.b_sel  = b;
    u.acc_op = a;
    u.wb     = w;
    u.seq    = s;
    u.target = tgt;
    return u;
  endfunction

  // Control program. Each word starts a product and folds in the product
  // that the previous word started.
  //   t0 = uy*v2 - uz*v1   t1 = uz*v0 - ux*v2   t2 = ux*v1 - uy*v0
  //   o_i = v_i + round((w*t_i + c_i) / 2^14), c = u x t
  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t u;
    case (pc)
      5'd0:  u = mk(Q_Y, B_V2, ACC_NOP,  WB_NONE,  SEQ_NEXT,     '0);
      5'd1:  u = mk(Q_Z, B_V1, ACC_LOAD, WB_NONE,  SEQ_NEXT,     '0);
      5'd2:  u = mk(Q_Z, B_V0, ACC_SUB,  WB_NONE,  SEQ_NEXT,     '0);
      5'd3:  u = mk(Q_X, B_V2, ACC_LOAD, WB_T0,    SEQ_NEXT,     '0);
      5'd4:  u = mk(Q_X, B_V1, ACC_SUB,  WB_NONE,  SEQ_NEXT,     '0);
      5'd5:  u = mk(Q_Y, B_V0, ACC_LOAD, WB_T1,    SEQ_NEXT,     '0);
      5'd6:  u = mk(Q_W, B_V0, ACC_SUB,  WB_NONE,  SEQ_NEXT,     '0);
      5'd7:  u = mk(Q_W, B_V0, ACC_NOP,  WB_T2,    SEQ_NEXT,     '0);
      5'd8:  u = mk(Q_W, B_T0, ACC_NOP,  WB_NONE,  SEQ_NEXT,     '0);
      5'd9:  u = mk(Q_Y, B_T2, ACC_LOAD, WB_NONE,  SEQ_NEXT,     '0);
      5'd10: u = mk(Q_Z, B_T1, ACC_ADD,  WB_NONE,  SEQ_NEXT,     '0);
      5'd11: u = mk(Q_W, B_T1, ACC_SUB,  WB_NONE,  SEQ_NEXT,     '0);
      5'd12: u = mk(Q_Z, B_T0, ACC_LOAD, WB_O0,    SEQ_NEXT,     '0);
      5'd13: u = mk(Q_X, B_T2, ACC_ADD,  WB_NONE,  SEQ_NEXT,     '0);
      5'd14: u = mk(Q_W, B_T2, ACC_SUB,  WB_NONE,  SEQ_NEXT,     '0);
      5'd15: u = mk(Q_X, B_T1, ACC_LOAD, WB_O1,    SEQ_NEXT,     '0);
      5'd16: u = mk(Q_Y, B_T0, ACC_ADD,  WB_NONE,  SEQ_NEXT,     '0);
      5'd17: u = mk(Q_W, B_V0, ACC_SUB,  WB_NONE,  SEQ_NEXT,     '0);
      5'd18: u = mk(Q_W, B_V0, ACC_NOP,  WB_O2,    SEQ_BRANCH_B, PC_EMIT);
      5'd19: u = mk(Q_W, B_V0, ACC_NOP,  WB_STORE, SEQ_HALT,     '0);
      5'd20: u = mk(Q_W, B_V0, ACC_NOP,  WB_EMIT,  SEQ_HALT,     '0);
      default: u = mk(Q_W, B_V0, ACC_NOP, WB_NONE, SEQ_HALT,     '0);
    endcase
    return u;
  endfunction

  // Flag a wide signed value that does not fit in PW bits
  function automatic logic clips(logic signed [SUMW-1:0] x);
    return !((&x[SUMW-1:PW-1]) || !(|x[SUMW-1:PW-1]));
  endfunction

  function automatic logic signed [PW-1:0] sat_pw(logic signed [SUMW-1:0] x);
    if (clips(x)) begin
      return x[SUMW-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
    end
    return x[PW-1:0];
  endfunction

endpackage

@@ src/ball_joint_constraint_terms.sv @@
// Ball-joint constraint terms: microcoded sequencer around one shared
// 16x37 multiplier and an accumulator. Depends on bjct_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one pose request: body
//   select, world position and orientation quaternion. Output channel
//   (out_valid_o/out_ready_i) returns one result per body B request:
//   violation, stored arm of body A, arm of body B and a clip flag.
//   Body A requests return nothing; they replace the stored arm and point.
//   Each request runs the control program: 19 shared steps (15 products
//   on the single multiplier, with their writebacks) plus one store or
//   emit step; the next request is accepted only once the program halts.
//   The result sits in an output register, so a new request is accepted
//   while the receiver stalls; the emit step holds only if that register
//   is still full when the next body B result is ready.
//   Anchors are written over cfg_we_i/cfg_idx_i/cfg_wdata_i while idle (a
//   rule for the user, not enforced by the block); indexes above five are
//   ignored. Reset clears anchors, stored arm and point, busy, pc, out valid.
module ball_joint_constraint_terms (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [bjct_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic        [bjct_pkg::PW-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 body_i,
  input  logic signed [bjct_pkg::PW-1:0]       pos_x_i,
  input  logic signed [bjct_pkg::PW-1:0]       pos_y_i,
  input  logic signed [bjct_pkg::PW-1:0]       pos_z_i,
  input  logic signed [bjct_pkg::QW-1:0]       quat_w_i,
  input  logic signed [bjct_pkg::QW-1:0]       quat_x_i,
  input  logic signed [bjct_pkg::QW-1:0]       quat_y_i,
  input  logic signed [bjct_pkg::QW-1:0]       quat_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [bjct_pkg::PW-1:0]       viol_x_o,
  output logic signed [bjct_pkg::PW-1:0]       viol_y_o,
  output logic signed [bjct_pkg::PW-1:0]       viol_z_o,
  output logic signed [bjct_pkg::PW-1:0]       arm_a_x_o,
  output logic signed [bjct_pkg::PW-1:0]       arm_a_y_o,
  output logic signed [bjct_pkg::PW-1:0]       arm_a_z_o,
  output logic signed [bjct_pkg::PW-1:0]       arm_b_x_o,
  output logic signed [bjct_pkg::PW-1:0]       arm_b_y_o,
  output logic signed [bjct_pkg::PW-1:0]       arm_b_z_o,
  output logic                                 saturated_o
);
  import bjct_pkg::*;

  // Control state
  logic              busy_q, busy_d;
  logic [PC_W-1:0]   pc_q, pc_d;
  logic              out_valid_q, out_valid_d;
  logic              sat_q;

  // Configuration and stored body A terms
  logic signed [PW-1:0]  anchor_a_q [3];
  logic signed [PW-1:0]  anchor_b_q [3];
  logic signed [PW-1:0]  saved_arm_q [3];
  logic signed [PTW-1:0] saved_pt_q [3];

  // Latched request and datapath
  logic                    body_q;
  logic signed [PW-1:0]    pos_q [3];
  logic signed [QW-1:0]    quat_q [4];
  logic signed [TW-1:0]    t_q [3];
  logic signed [PW-1:0]    arm_q [3];
  logic signed [PRODW-1:0] prod_q;
  logic signed [ACCW-1:0]  acc_q;
  logic signed [PW-1:0]    viol_q [3];
  logic signed [PW-1:0]    res_arm_a_q [3];
  logic signed [PW-1:0]    res_arm_b_q [3];
  logic                    res_sat_q;

  uword_t                  uw;
  logic                    accept;
  logic                    stall;
  logic                    step;
  logic signed [PW-1:0]    v_sel [3];
  logic signed [QW-1:0]    q_op;
  logic signed [TW-1:0]    b_op;
  logic signed [PRODW-1:0] prod_d;
  logic signed [ACCW-1:0]  acc_rnd_t;
  logic signed [ACCW-1:0]  acc_rnd_o;
  logic signed [TW-1:0]    t_new;
  logic signed [SUMW-1:0]  o_sum;
  logic signed [PW-1:0]    o_v;
  logic signed [SUMW-1:0]  viol_sum [3];
  logic [1:0]              o_idx;

  assign uw     = ucode(pc_q);
  assign accept = in_valid_i && in_ready_o;
  assign stall  = (uw.wb == WB_EMIT) && out_valid_q && !out_ready_i;
  assign step   = busy_q && !stall;

  assign in_ready_o = !busy_q;

  // Anchor of the body being rotated
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_sel[i] = body_q ? anchor_b_q[i] : anchor_a_q[i];
    end
  end

  // Multiplier operand select
  always_comb begin
    case (uw.q_sel)
      Q_W:     q_op = quat_q[0];
      Q_X:     q_op = quat_q[1];
      Q_Y:     q_op = quat_q[2];
      default: q_op = quat_q[3];
    endcase
    case (uw.b_sel)
      B_V0:    b_op = TW'(v_sel[0]);
      B_V1:    b_op = TW'(v_sel[1]);
      B_V2:    b_op = TW'(v_sel[2]);
      B_T0:    b_op = t_q[0];
      B_T1:    b_op = t_q[1];
      default: b_op = t_q[2];
    endcase
  end

  assign prod_d = PRODW'(q_op) * PRODW'(b_op);

  // Rounding of the accumulator, ties toward plus infinity
  assign acc_rnd_t = (acc_q + ACCW'(1 << (T_SHIFT - 1))) >>> T_SHIFT;
  assign acc_rnd_o = (acc_q + ACCW'(1 << (O_SHIFT - 1))) >>> O_SHIFT;
  assign t_new     = acc_rnd_t[TW-1:0];

  // Rotated component: anchor plus rounded rotation term
  always_comb begin
    case (uw.wb)
      WB_O0:   o_idx = 2'd0;
      WB_O1:   o_idx = 2'd1;
      default: o_idx = 2'd2;
    endcase
    o_v   = v_sel[o_idx];
    o_sum = SUMW'(o_v) + acc_rnd_o[SUMW-1:0];
  end

  // Violation against the stored body A point
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      viol_sum[i] = SUMW'(pos_q[i]) + SUMW'(arm_q[i]) - SUMW'(saved_pt_q[i]);
    end
  end

  // Sequencer: step counter with branch on body select
  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
      pc_d   = '0;
    end else if (step) begin
      unique case (uw.seq)
        SEQ_NEXT:     pc_d = pc_q + 1'b1;
        SEQ_BRANCH_B: pc_d = body_q ? uw.target : pc_q + 1'b1;
        SEQ_HALT:     busy_d = 1'b0;
        default:      busy_d = 1'b0;
      endcase
      if (uw.wb == WB_EMIT) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Anchor registers and stored body A terms
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        anchor_a_q[i]  <= '0;
        anchor_b_q[i]  <= '0;
        saved_arm_q[i] <= '0;
        saved_pt_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ANCHOR_A_X: anchor_a_q[0] <= cfg_wdata_i;
          REG_ANCHOR_A_Y: anchor_a_q[1] <= cfg_wdata_i;
          REG_ANCHOR_A_Z: anchor_a_q[2] <= cfg_wdata_i;
          REG_ANCHOR_B_X: anchor_b_q[0] <= cfg_wdata_i;
          REG_ANCHOR_B_Y: anchor_b_q[1] <= cfg_wdata_i;
          REG_ANCHOR_B_Z: anchor_b_q[2] <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (step && uw.wb == WB_STORE) begin
        for (int i = 0; i < 3; i++) begin
          saved_arm_q[i] <= arm_q[i];
          saved_pt_q[i]  <= PTW'(pos_q[i]) + PTW'(arm_q[i]);
        end
      end
    end
  end

  // Datapath: request latch, product, accumulator, writeback
  always_ff @(posedge clk_i) begin
    if (accept) begin
      body_q    <= body_i;
      pos_q[0]  <= pos_x_i;
      pos_q[1]  <= pos_y_i;
      pos_q[2]  <= pos_z_i;
      quat_q[0] <= quat_w_i;
      quat_q[1] <= quat_x_i;
      quat_q[2] <= quat_y_i;
      quat_q[3] <= quat_z_i;
      sat_q     <= 1'b0;
    end else if (step) begin
      prod_q <= prod_d;
      case (uw.acc_op)
        ACC_LOAD: acc_q <= ACCW'(prod_q);
        ACC_ADD:  acc_q <= acc_q + ACCW'(prod_q);
        ACC_SUB:  acc_q <= acc_q - ACCW'(prod_q);
        default:  ;
      endcase
      case (uw.wb)
        WB_T0: t_q[0] <= t_new;
        WB_T1: t_q[1] <= t_new;
        WB_T2: t_q[2] <= t_new;
        WB_O0, WB_O1, WB_O2: begin
          arm_q[o_idx] <= sat_pw(o_sum);
          if (clips(o_sum)) begin
            sat_q <= 1'b1;
          end
        end
        WB_EMIT: begin
          for (int i = 0; i < 3; i++) begin
            viol_q[i]      <= sat_pw(viol_sum[i]);
            res_arm_a_q[i] <= saved_arm_q[i];
            res_arm_b_q[i] <= arm_q[i];
          end
          res_sat_q <= sat_q || clips(viol_sum[0]) || clips(viol_sum[1]) ||
                       clips(viol_sum[2]);
        end
        default: ;
      endcase
    end
  end

  // Result register drives the output channel
  assign out_valid_o = out_valid_q;
  assign viol_x_o    = viol_q[0];
  assign viol_y_o    = viol_q[1];
  assign viol_z_o    = viol_q[2];
  assign arm_a_x_o   = res_arm_a_q[0];
  assign arm_a_y_o   = res_arm_a_q[1];
  assign arm_a_z_o   = res_arm_a_q[2];
  assign arm_b_x_o   = res_arm_b_q[0];
  assign arm_b_y_o   = res_arm_b_q[1];
  assign arm_b_z_o   = res_arm_b_q[2];
  assign saturated_o = res_sat_q;

endmodule

@@ dv/tb.sv @@
// Testbench for ball_joint_constraint_terms: directed table, then random poses
// over several anchor settings, checked against an in-bench fixed-point predictor.
// Depends on bjct_pkg and the ball_joint_constraint_terms RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bjct_pkg::*;

  localparam int CLK_HALF_NS  = 10;
  localparam int RESET_CYCLES = 6;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_ITEMS  = 150;
  localparam int STEADY_FROM  = 500;
  localparam int STEADY_TO    = 620;

  localparam logic [CFG_IW-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IW-1:0] REG_UNUSED_HI = 3'd7;

  localparam logic [PW-1:0] P_MAX = 32'h7fff_ffff;
  localparam logic [PW-1:0] P_MIN = 32'h8000_0000;
  localparam logic [PW-1:0] P_ONE = 32'h0001_0000;
  localparam logic [QW-1:0] Q_ONE = 16'h4000;
  localparam logic [QW-1:0] Q_NEG = 16'hc000;
  localparam logic [QW-1:0] Q_MAX = 16'h7fff;
  localparam logic [QW-1:0] Q_MIN = 16'h8000;
  localparam logic [QW-1:0] Q_HALF_TURN = 16'd11585;   // cos 45 deg in Q1.14

  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;

  typedef enum logic {ROW_POSE, ROW_CFG} row_kind_e;
  typedef enum int {ANCH_SMALL, ANCH_MAX, ANCH_MIN, ANCH_FULL, ANCH_ZERO, ANCH_MIXED}
    anchor_mode_e;

  typedef struct packed {
    logic            body;
    logic [2:0][PW-1:0] pos;
    logic [3:0][QW-1:0] quat;   // w, x, y, z
  } pose_t;

  typedef struct packed {
    logic [2:0][PW-1:0] viol;
    logic [2:0][PW-1:0] arm_a;
    logic [2:0][PW-1:0] arm_b;
    logic               sat;
  } joint_terms_t;

  typedef struct packed {
    logic [2:0][PW-1:0] arm;
    logic               clip;
  } turned_t;

  typedef struct packed {
    row_kind_e         kind;
    logic [CFG_IW-1:0] idx;
    logic [PW-1:0]     data;
    pose_t             pose;
    logic              has_known;
    joint_terms_t      known;
  } step_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IW-1:0] cfg_idx_i;
  logic [PW-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  logic body_i;
  logic signed [PW-1:0] pos_x_i, pos_y_i, pos_z_i;
  logic signed [QW-1:0] quat_w_i, quat_x_i, quat_y_i, quat_z_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [PW-1:0] viol_x_o, viol_y_o, viol_z_o;
  logic signed [PW-1:0] arm_a_x_o, arm_a_y_o, arm_a_z_o;
  logic signed [PW-1:0] arm_b_x_o, arm_b_y_o, arm_b_z_o;
  logic saturated_o;

  // Predictor state: local anchors per body, held arm and point of body A
  longint anchor_local [2][3];
  longint held_arm_a [3];
  longint held_point_a [3];

  joint_terms_t terms_due [$];
  int  fail_count = 0;
  int  cycle_count = 0;
  bit  steady = 1'b0;

  ball_joint_constraint_terms dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .body_i,
    .pos_x_i, .pos_y_i, .pos_z_i,
    .quat_w_i, .quat_x_i, .quat_y_i, .quat_z_i,
    .out_valid_o, .out_ready_i,
    .viol_x_o, .viol_y_o, .viol_z_o,
    .arm_a_x_o, .arm_a_y_o, .arm_a_z_o,
    .arm_b_x_o, .arm_b_y_o, .arm_b_z_o,
    .saturated_o
  );

  always #CLK_HALF_NS clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  // Round to nearest, ties toward plus infinity
  function automatic longint round_shift(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip32(longint x, inout bit hit);
    if (x > S32_HI) begin
      hit = 1'b1;
      return S32_HI;
    end
    if (x < S32_LO) begin
      hit = 1'b1;
      return S32_LO;
    end
    return x;
  endfunction

  // Rotate the local anchor of one body by q: t = 2(u x v), v' = v + w t + u x t
  function automatic turned_t turn_anchor(logic [3:0][QW-1:0] q, logic b);
    longint w, ux, uy, uz;
    longint v [3];
    longint t [3];
    longint c [3];
    bit hit;
    turned_t r;
    int i;
    w  = longint'($signed(q[0]));
    ux = longint'($signed(q[1]));
    uy = longint'($signed(q[2]));
    uz = longint'($signed(q[3]));
    for (i = 0; i < 3; i++) v[i] = anchor_local[int'(b)][i];
    t[0] = round_shift(uy * v[2] - uz * v[1], T_SHIFT);
    t[1] = round_shift(uz * v[0] - ux * v[2], T_SHIFT);
    t[2] = round_shift(ux * v[1] - uy * v[0], T_SHIFT);
    c[0] = uy * t[2] - uz * t[1];
    c[1] = uz * t[0] - ux * t[2];
    c[2] = ux * t[1] - uy * t[0];
    hit = 1'b0;
    for (i = 0; i < 3; i++)
      r.arm[i] = PW'(clip32(v[i] + round_shift(w * t[i] + c[i], O_SHIFT), hit));
    r.clip = hit;
    return r;
  endfunction

  // Advance the predictor by one pose; return 1 when a result is due
  function automatic bit predict_joint_terms(pose_t p, output joint_terms_t e);
    turned_t tr;
    bit hit;
    int i;
    tr = turn_anchor(p.quat, p.body);
    e = '0;
    if (!p.body) begin
      for (i = 0; i < 3; i++) begin
        held_arm_a[i]   = longint'($signed(tr.arm[i]));
        held_point_a[i] = longint'($signed(p.pos[i])) + held_arm_a[i];
      end
      return 1'b0;
    end
    hit = tr.clip;
    for (i = 0; i < 3; i++) begin
      e.viol[i]  = PW'(clip32(longint'($signed(p.pos[i])) + longint'($signed(tr.arm[i]))
                              - held_point_a[i], hit));
      e.arm_a[i] = PW'(held_arm_a[i]);
      e.arm_b[i] = tr.arm[i];
    end
    e.sat = hit;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_word(string name, logic [PW-1:0] want, logic [PW-1:0] got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", name, $signed(want), $signed(got));
      fail_count++;
    end
  endfunction

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : result_monitor
    joint_terms_t seen, want;
    string ax;
    int i;
    ax = "xyz";
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.viol  = {viol_z_o, viol_y_o, viol_x_o};
      seen.arm_a = {arm_a_z_o, arm_a_y_o, arm_a_x_o};
      seen.arm_b = {arm_b_z_o, arm_b_y_o, arm_b_x_o};
      seen.sat   = saturated_o;
      if (terms_due.size() == 0) begin
        $error("result accepted with no body B request outstanding");
        fail_count++;
      end else begin
        want = terms_due.pop_front();
        for (i = 0; i < 3; i++) begin
          check_word({"viol_", ax.substr(i, i)}, want.viol[i], seen.viol[i]);
          check_word({"arm_a_", ax.substr(i, i)}, want.arm_a[i], seen.arm_a[i]);
          check_word({"arm_b_", ax.substr(i, i)}, want.arm_b[i], seen.arm_b[i]);
        end
        if (seen.sat !== want.sat) begin
          $error("saturated expected %0b actual %0b", want.sat, seen.sat);
          fail_count++;
        end
      end
    end
  end

  // Stall the receiver at random cycles, none while steady
  always @(posedge clk_i or negedge rst_ni) begin : result_stall
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (steady) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 36);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ball_joint_constraint_terms test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic step_row_t pose_row(input logic b,
                                         input logic [PW-1:0] px, py, pz,
                                         input logic [QW-1:0] qw, qx, qy, qz);
    step_row_t r;
    r = '0;
    r.kind = ROW_POSE;
    r.pose.body = b;
    r.pose.pos  = {pz, py, px};
    r.pose.quat = {qz, qy, qx, qw};
    return r;
  endfunction

  // Attach a hand-written result to a row; arms are zero in these rows
  function automatic step_row_t with_known(step_row_t r, logic [PW-1:0] vx, vy, vz,
                                           logic s);
    r.has_known  = 1'b1;
    r.known      = '0;
    r.known.viol = {vz, vy, vx};
    r.known.sat  = s;
    return r;
  endfunction

  function automatic step_row_t cfg_row(logic [CFG_IW-1:0] idx, logic [PW-1:0] data);
    step_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic logic [PW-1:0] random_pos();
    int mode;
    mode = $urandom_range(99);
    if (mode < 70) return PW'(int'($urandom_range(0, 33554432)) - 16777216);
    if (mode < 90) return $urandom;
    case ($urandom_range(4))
      0: return P_MAX;
      1: return P_MIN;
      2: return '0;
      3: return '1;
      default: return P_ONE;
    endcase
  endfunction

  function automatic logic [QW-1:0] extreme_quat_part();
    case ($urandom_range(4))
      0: return Q_MIN;
      1: return Q_NEG;
      2: return '0;
      3: return Q_ONE;
      default: return Q_MAX;
    endcase
  endfunction

  function automatic pose_t random_pose(logic b);
    pose_t p;
    real a [4];
    real n;
    int mode;
    int i;
    p.body = b;
    for (i = 0; i < 3; i++) p.pos[i] = random_pos();
    mode = $urandom_range(99);
    if (mode < 65) begin
      // unit quaternion from a random direction in 4-space
      n = 0.0;
      for (i = 0; i < 4; i++) begin
        a[i] = real'(int'($urandom_range(0, 2000)) - 1000);
        n += a[i] * a[i];
      end
      n = $sqrt(n);
      for (i = 0; i < 4; i++)
        p.quat[i] = (n < 1.0) ? ((i == 0) ? Q_ONE : '0) : QW'($rtoi(a[i] / n * 16384.0));
    end else begin
      for (i = 0; i < 4; i++) begin
        if (mode < 80) p.quat[i] = QW'(int'($urandom_range(0, 32768)) - 16384);
        else if (mode < 95) p.quat[i] = QW'($urandom);
        else p.quat[i] = extreme_quat_part();
      end
    end
    return p;
  endfunction

  function automatic logic [PW-1:0] anchor_value(anchor_mode_e mode);
    case (mode)
      ANCH_SMALL: return PW'(int'($urandom_range(0, 2097152)) - 1048576);
      ANCH_MAX:   return P_MAX;
      ANCH_MIN:   return P_MIN;
      ANCH_FULL:  return $urandom;
      ANCH_ZERO:  return '0;
      default:    return anchor_value(anchor_mode_e'($urandom_range(0, 4)));
    endcase
  endfunction

  // Hold the request until accepted, then advance the predictor
  task automatic offer_pose(pose_t p, logic has_known, joint_terms_t known);
    joint_terms_t e;
    if (!steady && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    body_i     <= p.body;
    pos_x_i    <= p.pos[0];
    pos_y_i    <= p.pos[1];
    pos_z_i    <= p.pos[2];
    quat_w_i   <= p.quat[0];
    quat_x_i   <= p.quat[1];
    quat_y_i   <= p.quat[2];
    quat_z_i   <= p.quat[3];
    do @(posedge clk_i); while (!in_ready_o);
    if (predict_joint_terms(p, e)) terms_due.push_back(has_known ? known : e);
  endtask

  // Drop valid, drain outstanding results and let a body A request finish
  task automatic settle_requests();
    in_valid_i <= 1'b0;
    while (terms_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; the caller lowers the write enable after the last one
  task automatic write_anchor(logic [CFG_IW-1:0] idx, logic [PW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx <= REG_ANCHOR_A_Z)
      anchor_local[0][idx - REG_ANCHOR_A_X] = longint'($signed(data));
    else if (idx <= REG_ANCHOR_B_Z)
      anchor_local[1][idx - REG_ANCHOR_B_X] = longint'($signed(data));
  endtask

  task automatic load_anchors(anchor_mode_e mode);
    int i;
    for (i = 0; i < 6; i++) write_anchor(REG_ANCHOR_A_X + CFG_IW'(i), anchor_value(mode));
    write_anchor($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO, $urandom);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    step_row_t directed [$];
    anchor_mode_e phase_plan [7];
    step_row_t r;
    bit cfg_open;
    int ph, k, n_b, item;
    int i;

    for (i = 0; i < 3; i++) begin
      anchor_local[0][i] = 0;
      anchor_local[1][i] = 0;
      held_arm_a[i]      = 0;
      held_point_a[i]    = 0;
    end
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    body_i      <= 1'b0;
    pos_x_i     <= '0;
    pos_y_i     <= '0;
    pos_z_i     <= '0;
    quat_w_i    <= '0;
    quat_x_i    <= '0;
    quat_y_i    <= '0;
    quat_z_i    <= '0;

    // Body B before any body A, with zero anchors: violation is the position
    directed.push_back(with_known(pose_row(1'b1, P_ONE, 32'h0002_0000, 32'hfffd_0000,
                                           Q_ONE, '0, '0, '0),
                                  P_ONE, 32'h0002_0000, 32'hfffd_0000, 1'b0));
    directed.push_back(with_known(pose_row(1'b1, P_MAX, P_MIN, '0, Q_MIN, Q_MIN, Q_MIN, Q_MIN),
                                  P_MAX, P_MIN, '0, 1'b0));
    // Opposite extremes clip the violation
    directed.push_back(pose_row(1'b0, P_MIN, P_MIN, P_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    directed.push_back(with_known(pose_row(1'b1, P_MAX, P_MAX, P_MAX, Q_ONE, '0, '0, '0),
                                  P_MAX, P_MAX, P_MAX, 1'b1));
    directed.push_back(pose_row(1'b0, P_MAX, P_MAX, P_MAX, Q_ONE, '0, '0, '0));
    directed.push_back(with_known(pose_row(1'b1, P_MIN, P_MIN, P_MIN, Q_ONE, '0, '0, '0),
                                  P_MIN, P_MIN, P_MIN, 1'b1));
    directed.push_back(with_known(pose_row(1'b1, '0, '0, '0, Q_ONE, '0, '0, '0),
                                  32'h8000_0001, 32'h8000_0001, 32'h8000_0001, 1'b0));
    // Unit and half-unit anchors, plain rotations and unnormalized quaternions
    directed.push_back(cfg_row(REG_ANCHOR_A_X, P_ONE));
    directed.push_back(cfg_row(REG_ANCHOR_A_Y, '0));
    directed.push_back(cfg_row(REG_ANCHOR_A_Z, '0));
    directed.push_back(cfg_row(REG_ANCHOR_B_X, '0));
    directed.push_back(cfg_row(REG_ANCHOR_B_Y, P_ONE));
    directed.push_back(cfg_row(REG_ANCHOR_B_Z, 32'hffff_8000));
    directed.push_back(cfg_row(REG_UNUSED_LO, 32'hdead_beef));
    directed.push_back(cfg_row(REG_UNUSED_HI, 32'h5555_aaaa));
    directed.push_back(pose_row(1'b0, '0, '0, '0, Q_ONE, '0, '0, '0));
    directed.push_back(pose_row(1'b1, '0, '0, '0, Q_ONE, '0, '0, '0));
    directed.push_back(pose_row(1'b0, P_ONE, '0, '0, Q_HALF_TURN, '0, '0, Q_HALF_TURN));
    directed.push_back(pose_row(1'b1, '0, P_ONE, '0, Q_HALF_TURN, Q_HALF_TURN, '0, '0));
    directed.push_back(pose_row(1'b1, '0, '0, '0, '0, Q_ONE, '0, '0));
    directed.push_back(pose_row(1'b1, '0, '0, '0, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    directed.push_back(pose_row(1'b1, '0, '0, '0, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    directed.push_back(pose_row(1'b1, '0, '0, '0, Q_NEG, '0, '0, '0));
    // Clipped arm of body A must not raise the flag of a later result
    directed.push_back(cfg_row(REG_ANCHOR_A_X, P_MAX));
    directed.push_back(cfg_row(REG_ANCHOR_A_Y, P_MAX));
    directed.push_back(cfg_row(REG_ANCHOR_A_Z, P_MAX));
    directed.push_back(cfg_row(REG_ANCHOR_B_X, '0));
    directed.push_back(cfg_row(REG_ANCHOR_B_Y, '0));
    directed.push_back(cfg_row(REG_ANCHOR_B_Z, '0));
    directed.push_back(pose_row(1'b0, P_MIN, P_MIN, P_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    directed.push_back(pose_row(1'b1, P_MIN, P_MIN, P_MIN, Q_ONE, '0, '0, '0));
    directed.push_back(pose_row(1'b0, '0, '0, '0, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
    directed.push_back(pose_row(1'b0, P_MAX, '0, P_MIN, '0, '0, '0, Q_ONE));
    directed.push_back(cfg_row(REG_ANCHOR_B_X, P_MIN));
    directed.push_back(cfg_row(REG_ANCHOR_B_Y, P_MIN));
    directed.push_back(cfg_row(REG_ANCHOR_B_Z, P_MIN));
    directed.push_back(pose_row(1'b1, '0, '0, '0, Q_ONE, '0, '0, '0));
    directed.push_back(pose_row(1'b1, P_MIN, P_MAX, '0, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
    directed.push_back(pose_row(1'b1, P_MAX, P_MAX, P_MAX, '0, '0, Q_ONE, '0));

    phase_plan = '{ANCH_SMALL, ANCH_MAX, ANCH_MIN, ANCH_FULL, ANCH_ZERO, ANCH_MIXED,
                   ANCH_SMALL};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    cfg_open = 1'b0;
    foreach (directed[i]) begin
      r = directed[i];
      if (r.kind == ROW_CFG) begin
        if (!cfg_open) begin
          settle_requests();
          cfg_open = 1'b1;
        end
        write_anchor(r.idx, r.data);
      end else begin
        if (cfg_open) begin
          cfg_we_i <= 1'b0;
          cfg_open = 1'b0;
        end
        offer_pose(r.pose, r.has_known, r.known);
      end
    end

    // Random phases: mostly body A followed by one to three body B poses
    item = 0;
    for (ph = 0; ph < 7; ph++) begin
      settle_requests();
      load_anchors(phase_plan[ph]);
      k = 0;
      while (k < PHASE_ITEMS) begin
        if ($urandom_range(99) < 75) begin
          offer_pose(random_pose(1'b0), 1'b0, '0);
          n_b = $urandom_range(1, 3);
          for (i = 0; i < n_b; i++) offer_pose(random_pose(1'b1), 1'b0, '0);
          k += n_b + 1;
          item += n_b + 1;
        end else begin
          offer_pose(random_pose(1'($urandom_range(0, 1))), 1'b0, '0);
          k++;
          item++;
        end
        steady = (item >= STEADY_FROM) && (item < STEADY_TO);
      end
    end
    steady = 1'b0;

    settle_requests();
    if (fail_count == 0) begin
      $display("ball_joint_constraint_terms test passed");
    end else begin
      $display("ball_joint_constraint_terms test failed");
    end
    $finish;
  end

endmodule
